// ===== hdl/pps_pkg.sv =====
package pps_pkg;
	localparam int VALUE_BITS_DEF = 16;
	localparam int NUM_STAGES_DEF = 64;
	localparam int SMALLEST_PRIME = 2;
endpackage

// ===== hdl/pps_if.sv =====
interface pps_in_if #(parameter int VALUE_BITS = 16) ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] candidate;
	modport source (output valid, output candidate, input ready);
	modport sink (input valid, input candidate, output ready);
endinterface

interface pps_out_if #(parameter int VALUE_BITS = 16) ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] prime_value;
	logic                  table_full;
	modport source (output valid, output prime_value, output table_full, input ready);
	modport sink (input valid, input prime_value, input table_full, output ready);
endinterface

// ===== hdl/pipelined_prime_sieve.sv =====
// Prime sieve by trial division over a stream of candidates. Each accepted
// word is tested against the stored primes one stage at a time by a shared
// bit-serial remainder unit. A stage runs fetch, load, VALUE_BITS shift steps
// and check. The input is ready again in the same cycle a survivor is offered.
// A dropped word frees the input after its dividing stage. A stalled result
// holds the next survivor until it is taken. The prime table is a memory read
// once per stage. Survivors are stored in the next free stage and emitted;
// with every stage in use they are emitted with table_full set and not stored.
// Candidates 0 and 1 are dropped. No clearing pass: only written entries are
// read.
module pipelined_prime_sieve #(
	parameter int VALUE_BITS = pps_pkg::VALUE_BITS_DEF,
	parameter int NUM_STAGES = pps_pkg::NUM_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	pps_in_if.sink   in_ch,
	pps_out_if.source out_ch
);
	import pps_pkg::*;

	localparam int IW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
	localparam int CW = $clog2(NUM_STAGES + 1);
	localparam int BW = $clog2(VALUE_BITS + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_LOAD, ST_DIV, ST_CHECK, ST_DONE} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] cand_q;
	logic [VALUE_BITS-1:0] shift_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] div_q;
	logic [BW-1:0]         bit_q;
	logic [CW-1:0]         used_q;
	logic [CW-1:0]         idx_q;
	logic [VALUE_BITS-1:0] mem [NUM_STAGES];
	logic [VALUE_BITS-1:0] rd_q;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] out_val_q;
	logic                  out_full_q;
	logic [VALUE_BITS:0]   rem_sh;
	logic [VALUE_BITS:0]   rem_sub;

	// one quotient bit per cycle
	assign rem_sh  = {rem_q, shift_q[VALUE_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, div_q};

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.prime_value = out_val_q;
	assign out_ch.table_full  = out_full_q;

	always_ff @(posedge clk) begin
		rd_q <= mem[idx_q[IW-1:0]];
		if (state_q == ST_DONE && !out_valid_q && used_q < CW'(NUM_STAGES))
			mem[used_q[IW-1:0]] <= cand_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						cand_q <= in_ch.candidate;
						idx_q  <= '0;
						if (in_ch.candidate >= VALUE_BITS'(SMALLEST_PRIME))
							state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					// memory read address settles, data lands in rd_q
					if (idx_q >= used_q)
						state_q <= ST_DONE;
					else
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					div_q   <= rd_q;
					shift_q <= cand_q;
					rem_q   <= '0;
					bit_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
					if (!rem_sub[VALUE_BITS])
						rem_q <= rem_sub[VALUE_BITS-1:0];
					else
						rem_q <= rem_sh[VALUE_BITS-1:0];
					bit_q <= bit_q + 1'b1;
					if (bit_q == BW'(VALUE_BITS - 1))
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (rem_q == '0)
						state_q <= ST_IDLE;
					else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_val_q   <= cand_q;
						out_full_q  <= (used_q >= CW'(NUM_STAGES));
						if (used_q < CW'(NUM_STAGES))
							used_q <= used_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/pps_checker.sv =====
module pps_checker #(
	parameter int VALUE_BITS = pps_pkg::VALUE_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [VALUE_BITS-1:0] candidate,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [VALUE_BITS-1:0] prime_value,
	input logic                  table_full
);
	import pps_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prime_value) && $stable(table_full))
		else $error("result word changed while stalled");
	a_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> prime_value >= VALUE_BITS'(SMALLEST_PRIME))
		else $error("result below two");
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full && out_ready ##1 out_valid |-> table_full)
		else $error("table full flag cleared");
	// words below two are dropped at once and leave the input ready
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && candidate >= VALUE_BITS'(SMALLEST_PRIME) |=> !in_ready)
		else $error("second word taken while busy");
endmodule

bind pipelined_prime_sieve pps_checker #(.VALUE_BITS(VALUE_BITS)) u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .candidate(in_ch.candidate),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.prime_value(out_ch.prime_value), .table_full(out_ch.table_full)
);

// ===== verif/pipelined_prime_sieve_checker.sv =====
`timescale 1ns / 100ps
module pipelined_prime_sieve_checker #(
	parameter int VALUE_BITS = pps_pkg::VALUE_BITS_DEF,
	parameter int NUM_STAGES = pps_pkg::NUM_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	pps_in_if.sink   in_mon,
	pps_out_if.sink  out_mon,
	output int       fail_count,
	output int       pending_primes
);
	import pps_pkg::*;

	typedef struct packed {
		logic [VALUE_BITS-1:0] prime_value;
		logic                  table_full;
	} prime_word_t;

	logic [VALUE_BITS-1:0] known_primes[NUM_STAGES];
	int                    known_count;
	prime_word_t           expected_primes[$];

	assign pending_primes = expected_primes.size();

	// sieve the candidate against the table built so far
	function automatic void sieve_candidate(input logic [VALUE_BITS-1:0] cand);
		prime_word_t w;
		bit          divided;
		divided = 0;
		if (cand < SMALLEST_PRIME)
			return;
		for (int s = 0; s < known_count; s++)
			if (cand % known_primes[s] == 0)
				divided = 1;
		if (divided)
			return;
		w.prime_value = cand;
		w.table_full  = (known_count >= NUM_STAGES);
		if (!w.table_full) begin
			known_primes[known_count] = cand;
			known_count++;
		end
		expected_primes.push_back(w);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		prime_word_t want;
		if (!arst_n) begin
			known_count = 0;
			fail_count  = 0;
			expected_primes.delete();
		end else begin
			if (in_mon.valid && in_mon.ready)
				sieve_candidate(in_mon.candidate);
			if (out_mon.valid && out_mon.ready) begin
				if (expected_primes.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected word: prime %0d full %0b",
							out_mon.prime_value, out_mon.table_full);
				end else begin
					want = expected_primes.pop_front();
					if (want.prime_value !== out_mon.prime_value
							|| want.table_full !== out_mon.table_full) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected prime %0d full %0b, got %0d full %0b",
								want.prime_value, want.table_full,
								out_mon.prime_value, out_mon.table_full);
					end
				end
			end
		end
	end
endmodule

// ===== verif/pipelined_prime_sieve_tb.sv =====
`timescale 1ns / 100ps
module pipelined_prime_sieve_tb;
	import pps_pkg::*;
	localparam int VB = VALUE_BITS_DEF;
	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count;
	int   pending_primes;
	int   quiet_cycles = 0;
	bit   calm = 0;

	pps_in_if  #(.VALUE_BITS(VB)) in_ch ();
	pps_out_if #(.VALUE_BITS(VB)) out_ch ();

	pipelined_prime_sieve #(.VALUE_BITS(VB), .NUM_STAGES(NUM_STAGES_DEF)) i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	pipelined_prime_sieve_checker #(.VALUE_BITS(VB), .NUM_STAGES(NUM_STAGES_DEF)) i_checker (
		.clk(clk), .arst_n(arst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
		.fail_count(fail_count), .pending_primes(pending_primes)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	initial begin
		in_ch.valid     = 0;
		in_ch.candidate = '0;
		out_ch.ready    = 0;
	end

	// receiver stalls in bursts, none in the calm tail
	always @(posedge clk) begin
		int hold;
		if (arst_n) begin
			if (calm) begin
				out_ch.ready <= 1;
			end else if ($urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 12);
				out_ch.ready <= 0;
				repeat (hold) @(posedge clk);
				out_ch.ready <= 1;
			end else begin
				out_ch.ready <= 1;
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_word(input logic [VB-1:0] cand, input bit gaps);
		if (gaps && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_ch.valid     <= 1;
		in_ch.candidate <= cand;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain_primes();
		in_ch.valid <= 0;
		@(posedge clk);
		while (pending_primes != 0) @(posedge clk);
	endtask

	initial begin
		logic [VB-1:0] cand;
		int            next_cand;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: below two, small primes, repeats, all ones, out of order
		send_word(16'd0, 1'b0);
		send_word(16'd1, 1'b0);
		for (int v = 2; v <= 12; v++)
			send_word(v[VB-1:0], 1'b0);
		send_word(16'd7, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'hFFFB, 1'b0);
		send_word(16'd5, 1'b0);
		send_word(16'h8000, 1'b0);
		send_word(16'd13, 1'b0);
		drain_primes();

		// ascending run fills the table, then some
		next_cand = 14;
		for (int i = 0; i < 600; i++) begin
			send_word(next_cand[VB-1:0], 1'b1);
			next_cand++;
		end
		drain_primes();

		// table is full: mix of full-range and 300 to 2000 random words, survivors flagged
		for (int i = 0; i < 300; i++) begin
			if ($urandom_range(0, 3) == 0)
				cand = VB'($urandom);
			else
				cand = VB'($urandom_range(300, 2000));
			send_word(cand, 1'b1);
		end
		for (int i = 0; i < 30; i++)
			send_word(VB'($urandom_range(0, 1)), 1'b1);

		calm = 1;
		for (int i = 0; i < 100; i++)
			send_word(VB'($urandom), 1'b0);
		drain_primes();
		repeat (200) @(posedge clk);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/pps_pkg.sv
hdl/pps_if.sv
hdl/pipelined_prime_sieve.sv
hdl/pps_checker.sv
verif/pipelined_prime_sieve_checker.sv
verif/pipelined_prime_sieve_tb.sv
